// ----- hw/rtl/scr_pkg.sv -----
// Shared definitions for the stereo comb and allpass reverb.
// Holds register widths, register indexes, reset values and the lane request type.
// No dependencies; compile this file first.
`timescale 1ns / 1ps
`default_nettype none

package scr_pkg;

  // Default sizes of the delay lines and the sample word.
  localparam int COMB1_DEPTH_DEF   = 4096;
  localparam int COMB2_DEPTH_DEF   = 4096;
  localparam int ALLPASS_DEPTH_DEF = 512;
  localparam int SAMPLE_BITS_DEF   = 24;

  // Configuration register widths.
  localparam int LEN_W      = 13;
  localparam int AP_LEN_W   = 10;
  localparam int DECAY_W    = 16;
  localparam int MIX_W      = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;

  // Unity gain in Q1.16.
  localparam logic [MIX_W-1:0] MIX_ONE = 17'd65536;

  // Depth of the output queue, which also bounds the beats in flight.
  localparam int OUT_Q_DEPTH = 4;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_COMB1_LEN   = 3'd1,
    REG_COMB2_LEN   = 3'd2,
    REG_ALLPASS_LEN = 3'd3,
    REG_DECAY       = 3'd4,
    REG_MIX         = 3'd5
  } cfg_reg_t;

  // Register reset values.
  localparam logic [LEN_W-1:0]    COMB1_LEN_RST   = 13'd1425;
  localparam logic [LEN_W-1:0]    COMB2_LEN_RST   = 13'd1780;
  localparam logic [AP_LEN_W-1:0] ALLPASS_LEN_RST = 10'd240;
  localparam logic [DECAY_W-1:0]  DECAY_RST       = 16'd32768;
  localparam logic [MIX_W-1:0]    MIX_RST         = 17'd32768;

  // Per-beat control handed from the top level to each lane.
  typedef struct packed {
    logic start;   // a beat is accepted this cycle
    logic wet;     // reverb applied to this beat
    logic c1_hit;  // first comb entry has been written before
    logic c2_hit;  // second comb entry has been written before
    logic ap_hit;  // allpass entry has been written before
  } lane_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/scr_stream_if.sv -----
// Stream interfaces for the reverb: stereo input beats and stereo output beats.
// Each carries valid, ready and the two samples; depends on scr_pkg for the default width.
`timescale 1ns / 1ps
`default_nettype none

interface scr_in_if #(
  parameter int SAMPLE_BITS = scr_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;

  modport source (output valid, output sample_left, output sample_right, input ready);
  modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

interface scr_out_if #(
  parameter int SAMPLE_BITS = scr_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink (input valid, input out_left, input out_right, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/stereo_comb_allpass_reverb.sv -----
// Top level of the stereo reverb: configuration registers, shared position
// trackers, two channel lanes and the output stage.
// Depends on scr_pkg, the stream interfaces, scr_pos, scr_lane and scr_merge.
`timescale 1ns / 1ps
`default_nettype none

// Stereo reverb with two feedback combs and one allpass per channel. Input
// beats are never accepted back to back; the limit comes from each delay
// line's single RAM port pair, which is read for a sample and written back
// from the stage 2 registers. The left and right lanes run side by side and
// their results leave together as one output beat; a four-beat output queue
// lets input continue while results wait to be taken. The delay memories
// read as zero after reset without a clearing pass: a fill mark per line pair
// records which entries have been written, so the block accepts beats from
// the first cycle after reset. Configuration must only be written while no
// beat is in flight; writing enable or a length restarts the lines at their
// first entry but keeps their contents.
module stereo_comb_allpass_reverb #(
  parameter int COMB1_DEPTH   = scr_pkg::COMB1_DEPTH_DEF,
  parameter int COMB2_DEPTH   = scr_pkg::COMB2_DEPTH_DEF,
  parameter int ALLPASS_DEPTH = scr_pkg::ALLPASS_DEPTH_DEF,
  parameter int SAMPLE_BITS   = scr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  scr_in_if.sink                             audio_in,
  scr_out_if.source                          audio_out,
  input  logic                               cfg_we,
  input  logic [scr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import scr_pkg::*;

  localparam int C1_AW = $clog2(COMB1_DEPTH);
  localparam int C2_AW = $clog2(COMB2_DEPTH);
  localparam int AP_AW = $clog2(ALLPASS_DEPTH);
  localparam int INFL_W = $clog2(OUT_Q_DEPTH + 1);

  // Configuration registers.
  logic                enable;
  logic [LEN_W-1:0]    comb1_len;
  logic [LEN_W-1:0]    comb2_len;
  logic [AP_LEN_W-1:0] allpass_len;
  logic [DECAY_W-1:0]  decay_gain;
  logic [MIX_W-1:0]    mix_gain;
  logic [MIX_W-1:0]    mix_eff;
  logic                pos_clear;

  // Flow control.
  logic              accept;
  logic              accept_d;
  logic [INFL_W-1:0] inflight;
  logic              out_take;
  logic              step;

  // Position trackers.
  logic [C1_AW-1:0] c1_addr;
  logic [C2_AW-1:0] c2_addr;
  logic [AP_AW-1:0] ap_addr;
  logic             c1_hit, c2_hit, ap_hit;
  lane_req_t        req;

  // Lane results.
  logic signed [SAMPLE_BITS-1:0] y_left, y_right;
  logic                          done_left, done_right;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      comb1_len   <= COMB1_LEN_RST;
      comb2_len   <= COMB2_LEN_RST;
      allpass_len <= ALLPASS_LEN_RST;
      decay_gain  <= DECAY_RST;
      mix_gain    <= MIX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:      enable      <= cfg_data[0];
        REG_COMB1_LEN:   comb1_len   <= cfg_data[LEN_W-1:0];
        REG_COMB2_LEN:   comb2_len   <= cfg_data[LEN_W-1:0];
        REG_ALLPASS_LEN: allpass_len <= cfg_data[AP_LEN_W-1:0];
        REG_DECAY:       decay_gain  <= cfg_data[DECAY_W-1:0];
        REG_MIX:         mix_gain    <= cfg_data[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Writing enable or a length sends every line back to its first entry.
  assign pos_clear = cfg_we && (cfg_index inside {REG_ENABLE, REG_COMB1_LEN,
                                                  REG_COMB2_LEN, REG_ALLPASS_LEN});

  // A wet fraction above one acts as fully wet.
  assign mix_eff = (mix_gain > MIX_ONE) ? MIX_ONE : mix_gain;

  // Input beats are refused during reset, never accepted back to back and held
  // back while the output queue could not take every beat already in flight.
  assign accept         = audio_in.valid && audio_in.ready;
  assign audio_in.ready = !rst && !accept_d && (inflight < INFL_W'(OUT_Q_DEPTH));
  assign out_take       = audio_out.valid && audio_out.ready;
  assign step           = accept && enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_d <= 1'b0;
      inflight <= '0;
    end else begin
      accept_d <= accept;
      if (accept && !out_take) begin
        inflight <= inflight + 1'b1;
      end else if (out_take && !accept) begin
        inflight <= inflight - 1'b1;
      end
    end
  end

  // One position per line pair, shared by both channels.
  scr_pos #(.DEPTH(COMB1_DEPTH), .LEN_W(LEN_W)) u_pos_comb1 (
    .clk(clk), .rst(rst), .len(comb1_len), .clear(pos_clear), .step(step),
    .addr(c1_addr), .hit(c1_hit)
  );

  scr_pos #(.DEPTH(COMB2_DEPTH), .LEN_W(LEN_W)) u_pos_comb2 (
    .clk(clk), .rst(rst), .len(comb2_len), .clear(pos_clear), .step(step),
    .addr(c2_addr), .hit(c2_hit)
  );

  scr_pos #(.DEPTH(ALLPASS_DEPTH), .LEN_W(AP_LEN_W)) u_pos_allpass (
    .clk(clk), .rst(rst), .len(allpass_len), .clear(pos_clear), .step(step),
    .addr(ap_addr), .hit(ap_hit)
  );

  always_comb begin
    req.start  = accept;
    req.wet    = enable;
    req.c1_hit = c1_hit;
    req.c2_hit = c2_hit;
    req.ap_hit = ap_hit;
  end

  // Channel lanes.
  scr_lane #(
    .SAMPLE_BITS(SAMPLE_BITS), .COMB1_DEPTH(COMB1_DEPTH),
    .COMB2_DEPTH(COMB2_DEPTH), .ALLPASS_DEPTH(ALLPASS_DEPTH)
  ) u_lane_left (
    .clk(clk), .rst(rst), .req(req),
    .c1_addr(c1_addr), .c2_addr(c2_addr), .ap_addr(ap_addr),
    .x(audio_in.sample_left), .decay(decay_gain), .mix(mix_eff),
    .y(y_left), .done(done_left)
  );

  scr_lane #(
    .SAMPLE_BITS(SAMPLE_BITS), .COMB1_DEPTH(COMB1_DEPTH),
    .COMB2_DEPTH(COMB2_DEPTH), .ALLPASS_DEPTH(ALLPASS_DEPTH)
  ) u_lane_right (
    .clk(clk), .rst(rst), .req(req),
    .c1_addr(c1_addr), .c2_addr(c2_addr), .ap_addr(ap_addr),
    .x(audio_in.sample_right), .decay(decay_gain), .mix(mix_eff),
    .y(y_right), .done(done_right)
  );

  // Stereo output stage.
  scr_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk(clk), .rst(rst), .push(done_left),
    .left(y_left), .right(y_right), .out(audio_out)
  );

  // The two lanes run in lock step.
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    done_left == done_right)
    else $error("left and right lanes finished in different cycles");

  // A beat is never followed by another in the next cycle, which keeps the read
  // for the next beat from coming ahead of the write-back of the previous one.
  a_beat_spacing: assert property (@(posedge clk) disable iff (rst)
    accept |=> !accept)
    else $error("input beats accepted in consecutive cycles");

  // Beats in flight never exceed the room in the output queue.
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= INFL_W'(OUT_Q_DEPTH))
    else $error("more beats in flight than the output queue holds");

  // A waiting output beat is always counted as in flight.
  a_out_counted: assert property (@(posedge clk) disable iff (rst)
    audio_out.valid |-> (inflight != '0))
    else $error("output beat offered with nothing in flight");

endmodule

`default_nettype wire

// ----- hw/rtl/scr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read in the same cycle as a write to the same entry returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scr_pos.sv -----
// Position tracker for one delay line pair: clamped length, wrapping position and fill mark.
// Depends on scr_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module scr_pos #(
  parameter int DEPTH = scr_pkg::COMB1_DEPTH_DEF,
  parameter int LEN_W = scr_pkg::LEN_W,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] len,
  input  logic             clear,
  input  logic             step,
  output logic [AW-1:0]    addr,
  output logic             hit
);

  localparam int CW = (LEN_W > AW + 1) ? LEN_W : AW + 1;

  logic [AW-1:0] pos;
  logic [AW-1:0] pos_next;
  logic [AW:0]   fill;
  logic [AW:0]   fill_next;
  logic [CW-1:0] len_c;
  logic [CW-1:0] len_eff;
  logic [CW-1:0] step_c;

  // Length of zero acts as one, a length beyond the depth acts as the depth.
  always_comb begin
    len_c = CW'(len);
    if (len == '0) begin
      len_eff = CW'(1);
    end else if (len_c > CW'(DEPTH)) begin
      len_eff = CW'(DEPTH);
    end else begin
      len_eff = len_c;
    end
  end

  // Current position, forced to zero when it lies beyond the line.
  assign addr = (CW'(pos) < len_eff) ? pos : '0;

  // Writes always land at the fill mark or below it, so the written entries
  // form a prefix of the line and one count tells which reads see stored data.
  assign hit = ({1'b0, addr} < fill);

  always_comb begin
    step_c    = CW'(addr) + CW'(1);
    pos_next  = (step_c >= len_eff) ? '0 : step_c[AW-1:0];
    fill_next = ({1'b0, addr} == fill) ? fill + 1'b1 : fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      fill <= '0;
    end else if (clear) begin
      pos <= '0;
    end else if (step) begin
      pos  <= pos_next;
      fill <= fill_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scr_lane.sv -----
// One reverb channel: two feedback combs, averaging, allpass and wet/dry mix in four stages.
// Depends on scr_pkg and scr_ram.
`timescale 1ns / 1ps
`default_nettype none

module scr_lane #(
  parameter int SAMPLE_BITS   = scr_pkg::SAMPLE_BITS_DEF,
  parameter int COMB1_DEPTH   = scr_pkg::COMB1_DEPTH_DEF,
  parameter int COMB2_DEPTH   = scr_pkg::COMB2_DEPTH_DEF,
  parameter int ALLPASS_DEPTH = scr_pkg::ALLPASS_DEPTH_DEF,
  localparam int C1_AW = $clog2(COMB1_DEPTH),
  localparam int C2_AW = $clog2(COMB2_DEPTH),
  localparam int AP_AW = $clog2(ALLPASS_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  scr_pkg::lane_req_t              req,
  input  logic [C1_AW-1:0]                c1_addr,
  input  logic [C2_AW-1:0]                c2_addr,
  input  logic [AP_AW-1:0]                ap_addr,
  input  logic signed [SAMPLE_BITS-1:0]   x,
  input  logic [scr_pkg::DECAY_W-1:0]     decay,
  input  logic [scr_pkg::MIX_W-1:0]       mix,
  output logic signed [SAMPLE_BITS-1:0]   y,
  output logic                            done
);

  import scr_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int SW = SB + 4;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW - SB + 1){1'b1}}, {(SB - 1){1'b0}}};

  function automatic logic signed [SB-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SB-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SB-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  // Memory read ports.
  logic [SB-1:0] c1_rdata;
  logic [SB-1:0] c2_rdata;
  logic [SB-1:0] ap_rdata;

  // Stage 1 registers.
  logic                 vld1;
  logic                 wet1;
  logic signed [SB-1:0] x1;
  logic                 c1_hit1, c2_hit1, ap_hit1;
  logic                 c1_fwd1, c2_fwd1, ap_fwd1;
  logic signed [SB-1:0] c1_fdat1, c2_fdat1, ap_fdat1;
  logic [C1_AW-1:0]     c1_addr1;
  logic [C2_AW-1:0]     c2_addr1;
  logic [AP_AW-1:0]     ap_addr1;

  // Stage 2 registers.
  logic                 vld2;
  logic                 wet2;
  logic signed [SB-1:0] x2;
  logic signed [SB+16:0] c1_prod2, c2_prod2;
  logic signed [SB-1:0] ap_wdat2;
  logic signed [SB:0]   diff2;
  logic [C1_AW-1:0]     c1_addr2;
  logic [C2_AW-1:0]     c2_addr2;
  logic [AP_AW-1:0]     ap_addr2;

  // Stage 3 registers.
  logic                  vld3;
  logic                  wet3;
  logic signed [SB-1:0]  x3;
  logic signed [SB+17:0] dry_prod3;
  logic signed [SB+18:0] wet_prod3;

  // Stage 1 logic.
  logic signed [SB-1:0]  r1, r2, ra;
  logic signed [SB+16:0] c1_prod, c2_prod;
  logic signed [SB:0]    pair_sum;
  logic signed [SB-1:0]  avg;
  logic signed [SB-1:0]  ra_half;
  logic signed [SB:0]    ap_sum;
  logic signed [SB:0]    diff;

  // Stage 2 logic.
  logic                  wr2;
  logic signed [SB+1:0]  c1_sum, c2_sum;
  logic signed [SB-1:0]  c1_wdat, c2_wdat;
  logic [MIX_W-1:0]      dry_gain;
  logic signed [SB+17:0] dry_prod;
  logic signed [SB+18:0] wet_prod;

  // Stage 3 logic.
  logic signed [SB+19:0] acc;
  logic signed [SB-1:0]  y_next;

  // Delay lines.
  scr_ram #(.WIDTH(SB), .DEPTH(COMB1_DEPTH)) u_comb1 (
    .clk(clk), .we(wr2), .waddr(c1_addr2), .wdata(c1_wdat),
    .raddr(c1_addr), .rdata(c1_rdata)
  );

  scr_ram #(.WIDTH(SB), .DEPTH(COMB2_DEPTH)) u_comb2 (
    .clk(clk), .we(wr2), .waddr(c2_addr2), .wdata(c2_wdat),
    .raddr(c2_addr), .rdata(c2_rdata)
  );

  scr_ram #(.WIDTH(SB), .DEPTH(ALLPASS_DEPTH)) u_allpass (
    .clk(clk), .we(wr2), .waddr(ap_addr2), .wdata(ap_wdat2),
    .raddr(ap_addr), .rdata(ap_rdata)
  );

  // Stage 0: reads are issued. The previous beat may write the same entry in
  // this very cycle, so its write data is captured for forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= req.start;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x1       <= x;
      wet1     <= req.wet;
      c1_hit1  <= req.c1_hit;
      c2_hit1  <= req.c2_hit;
      ap_hit1  <= req.ap_hit;
      c1_fwd1  <= wr2 && (c1_addr2 == c1_addr);
      c2_fwd1  <= wr2 && (c2_addr2 == c2_addr);
      ap_fwd1  <= wr2 && (ap_addr2 == ap_addr);
      c1_fdat1 <= c1_wdat;
      c2_fdat1 <= c2_wdat;
      ap_fdat1 <= ap_wdat2;
      c1_addr1 <= c1_addr;
      c2_addr1 <= c2_addr;
      ap_addr1 <= ap_addr;
    end
  end

  // Stage 1: select stored, forwarded or never-written data, scale the comb
  // reads, average them and form the allpass store and output.
  always_comb begin
    r1 = c1_fwd1 ? c1_fdat1 : (c1_hit1 ? $signed(c1_rdata) : '0);
    r2 = c2_fwd1 ? c2_fdat1 : (c2_hit1 ? $signed(c2_rdata) : '0);
    ra = ap_fwd1 ? ap_fdat1 : (ap_hit1 ? $signed(ap_rdata) : '0);
    c1_prod  = (SB+17)'(r1) * (SB+17)'($signed({1'b0, decay}));
    c2_prod  = (SB+17)'(r2) * (SB+17)'($signed({1'b0, decay}));
    pair_sum = (SB+1)'(r1) + (SB+1)'(r2);
    avg      = $signed(pair_sum[SB:1]);
    ra_half  = ra >>> 1;
    ap_sum   = (SB+1)'(avg) + (SB+1)'(ra_half);
    diff     = (SB+1)'(ra) - (SB+1)'(avg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (vld1) begin
      x2       <= x1;
      wet2     <= wet1;
      c1_prod2 <= c1_prod;
      c2_prod2 <= c2_prod;
      ap_wdat2 <= sat(SW'(ap_sum));
      diff2    <= diff;
      c1_addr2 <= c1_addr1;
      c2_addr2 <= c2_addr1;
      ap_addr2 <= ap_addr1;
    end
  end

  // Stage 2: write the three lines back and multiply for the mix.
  always_comb begin
    wr2      = vld2 && wet2;
    c1_sum   = (SB+2)'(x2) + (SB+2)'($signed(c1_prod2[SB+16:16]));
    c2_sum   = (SB+2)'(x2) + (SB+2)'($signed(c2_prod2[SB+16:16]));
    c1_wdat  = sat(SW'(c1_sum));
    c2_wdat  = sat(SW'(c2_sum));
    dry_gain = MIX_ONE - mix;
    dry_prod = (SB+18)'(x2) * (SB+18)'($signed({1'b0, dry_gain}));
    wet_prod = (SB+19)'(diff2) * (SB+19)'($signed({1'b0, mix}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (vld2) begin
      x3        <= x2;
      wet3      <= wet2;
      dry_prod3 <= dry_prod;
      wet_prod3 <= wet_prod;
    end
  end

  // Stage 3: sum the products, scale back and saturate; bypass beats pass the input.
  always_comb begin
    acc    = (SB+20)'(dry_prod3) + (SB+20)'(wet_prod3);
    y_next = wet3 ? sat($signed(acc[SB+19:16])) : x3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (vld3) begin
      y <= y_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scr_merge.sv -----
// Output stage: joins the two lane results into one stereo beat and queues it.
// Depends on scr_pkg and the scr_out_if interface.
`timescale 1ns / 1ps
`default_nettype none

module scr_merge #(
  parameter int SAMPLE_BITS = scr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] left,
  input  logic signed [SAMPLE_BITS-1:0] right,
  scr_out_if.source                     out
);

  import scr_pkg::*;

  localparam int PW = $clog2(OUT_Q_DEPTH);
  localparam int CNT_W = $clog2(OUT_Q_DEPTH + 1);

  logic signed [SAMPLE_BITS-1:0] q_left  [OUT_Q_DEPTH];
  logic signed [SAMPLE_BITS-1:0] q_right [OUT_Q_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign out.valid     = (count != '0);
  assign out.out_left  = q_left[rd_ptr];
  assign out.out_right = q_right[rd_ptr];
  assign pop           = out.valid && out.ready;

  // The top level limits beats in flight to the queue depth, so a push always finds room.
  always_ff @(posedge clk) begin
    if (push) begin
      q_left[wr_ptr]  <= left;
      q_right[wr_ptr] <= right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(OUT_Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(OUT_Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sim/stereo_comb_allpass_reverb_tb.sv -----
// Self-checking testbench for the stereo comb and allpass reverb.
// Drives stereo beats with random idling, predicts each mixed pair and checks it.
// Depends on scr_pkg, the stream interfaces and the reverb top level.
`timescale 1ns / 1ps

module stereo_comb_allpass_reverb_tb;
  import scr_pkg::*;

  localparam int SB    = SAMPLE_BITS_DEF;
  localparam int C1_D  = COMB1_DEPTH_DEF;
  localparam int C2_D  = COMB2_DEPTH_DEF;
  localparam int AP_D  = ALLPASS_DEPTH_DEF;
  localparam int PHASE_ITEMS = 244;
  localparam int NUM_PHASES  = 8;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam longint SAT_HI = 64'sd8388607;
  localparam longint SAT_LO = -64'sd8388608;
  localparam logic signed [SB-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SB-1:0] S_MIN = 24'sh800000;

  typedef logic signed [SB-1:0] sample_t;
  typedef struct packed {
    sample_t left;
    sample_t right;
  } pair_t;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  scr_in_if  audio_in_if ();
  scr_out_if audio_out_if ();

  stereo_comb_allpass_reverb dut (
    .clk       (clk),
    .rst       (rst),
    .audio_in  (audio_in_if),
    .audio_out (audio_out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the configuration registers.
  logic                enable_cfg;
  logic [LEN_W-1:0]    comb1_len_cfg;
  logic [LEN_W-1:0]    comb2_len_cfg;
  logic [AP_LEN_W-1:0] allpass_len_cfg;
  logic [DECAY_W-1:0]  decay_cfg;
  logic [MIX_W-1:0]    mix_cfg;

  // Mirror of the delay lines and their positions; index 0 is left, 1 is right.
  sample_t comb1_mem [2][C1_D];
  sample_t comb2_mem [2][C2_D];
  sample_t allpass_mem [2][AP_D];
  int unsigned comb1_pos, comb2_pos, allpass_pos;

  pair_t pending_pairs_q [$];
  pair_t expected_mix_q [$];
  bit    in_busy;
  int    send_idle_pct;
  int    stall_pct;
  int    out_mismatches;

  function automatic longint clamp24(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic int unsigned eff_len(int unsigned len, int unsigned depth);
    if (len == 0) return 1;
    if (len > depth) return depth;
    return len;
  endfunction

  // One channel: two feedback combs, their average into a half-gain allpass, then the mix.
  function automatic sample_t reverb_channel(int ch, sample_t x, int unsigned p1,
                                             int unsigned p2, int unsigned pa, longint mix);
    longint xv, r1, r2, ra, d, avg, diff, acc;
    xv = x;
    r1 = comb1_mem[ch][p1];
    r2 = comb2_mem[ch][p2];
    ra = allpass_mem[ch][pa];
    d  = decay_cfg;
    comb1_mem[ch][p1] = sample_t'(clamp24(xv + ((r1 * d) >>> 16)));
    comb2_mem[ch][p2] = sample_t'(clamp24(xv + ((r2 * d) >>> 16)));
    avg = (r1 + r2) >>> 1;
    allpass_mem[ch][pa] = sample_t'(clamp24(avg + (ra >>> 1)));
    diff = ra - avg;
    acc  = xv * (64'sd65536 - mix) + diff * mix;
    return sample_t'(clamp24(acc >>> 16));
  endfunction

  function automatic pair_t reverb_predict(pair_t x);
    int unsigned l1, l2, la, p1, p2, pa;
    longint mix;
    pair_t y;
    if (!enable_cfg) return x;
    l1 = eff_len(comb1_len_cfg, C1_D);
    l2 = eff_len(comb2_len_cfg, C2_D);
    la = eff_len(allpass_len_cfg, AP_D);
    p1 = (comb1_pos < l1) ? comb1_pos : 0;
    p2 = (comb2_pos < l2) ? comb2_pos : 0;
    pa = (allpass_pos < la) ? allpass_pos : 0;
    mix = mix_cfg;
    if (mix > 65536) mix = 65536;
    y.left  = reverb_channel(0, x.left, p1, p2, pa, mix);
    y.right = reverb_channel(1, x.right, p1, p2, pa, mix);
    comb1_pos   = (p1 + 1 >= l1) ? 0 : p1 + 1;
    comb2_pos   = (p2 + 1 >= l2) ? 0 : p2 + 1;
    allpass_pos = (pa + 1 >= la) ? 0 : pa + 1;
    return y;
  endfunction

  // Register write as the block sees it; enable and lengths restart the positions.
  function automatic void mirror_cfg_write(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ENABLE:      enable_cfg = data[0];
      REG_COMB1_LEN:   comb1_len_cfg = data[LEN_W-1:0];
      REG_COMB2_LEN:   comb2_len_cfg = data[LEN_W-1:0];
      REG_ALLPASS_LEN: allpass_len_cfg = data[AP_LEN_W-1:0];
      REG_DECAY: begin
        decay_cfg = data[DECAY_W-1:0];
        return;
      end
      REG_MIX: begin
        mix_cfg = data[MIX_W-1:0];
        return;
      end
      default: return;
    endcase
    comb1_pos   = 0;
    comb2_pos   = 0;
    allpass_pos = 0;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return S_MAX;
          1: return S_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return sample_t'($urandom_range(8191)) - sample_t'(4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_len(int unsigned short_hi, int unsigned field_max);
    if ($urandom_range(7) == 0) return $urandom_range(field_max, 0);
    return $urandom_range(short_hi, 1);
  endfunction

  function automatic int unsigned pick_mix();
    case ($urandom_range(7))
      0: return 65536;
      1: return $urandom_range(131071, 65537);
      2: return 0;
      default: return $urandom_range(65535, 0);
    endcase
  endfunction

  // The beat is taken at the rising edge; its prediction is made then.
  always @(posedge clk) begin : in_accept
    if (!rst && audio_in_if.valid && audio_in_if.ready) begin
      expected_mix_q.push_back(reverb_predict({audio_in_if.sample_left,
                                               audio_in_if.sample_right}));
      in_busy = 1'b0;
    end
  end

  // Driver: holds a beat until taken, otherwise offers the next one or idles.
  always @(negedge clk) begin : in_driver
    pair_t nxt;
    if (rst) begin
      audio_in_if.valid <= 1'b0;
    end else if (!in_busy) begin
      if (pending_pairs_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_pairs_q.pop_front();
        audio_in_if.valid        <= 1'b1;
        audio_in_if.sample_left  <= nxt.left;
        audio_in_if.sample_right <= nxt.right;
        in_busy = 1'b1;
      end else begin
        audio_in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin : out_ready_driver
    if (rst) audio_out_if.ready <= 1'b0;
    else     audio_out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: each output beat is checked against the oldest prediction.
  always @(posedge clk) begin : out_monitor
    pair_t want;
    if (!rst && audio_out_if.valid && audio_out_if.ready) begin
      if (expected_mix_q.size() == 0) begin
        out_mismatches++;
        if (out_mismatches <= 10)
          $display("%0t: output beat L=%0d R=%0d with none expected", $realtime,
                   audio_out_if.out_left, audio_out_if.out_right);
      end else begin
        want = expected_mix_q.pop_front();
        if (audio_out_if.out_left !== want.left || audio_out_if.out_right !== want.right) begin
          out_mismatches++;
          if (out_mismatches <= 10)
            $display("%0t: mismatch left exp %0d got %0d, right exp %0d got %0d", $realtime,
                     want.left, audio_out_if.out_left, want.right, audio_out_if.out_right);
        end
      end
    end
  end

  task automatic drain_pipeline();
    while (pending_pairs_q.size() != 0 || in_busy || expected_mix_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Raises the write strobe and leaves it high; cfg_release drops it after a series.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    mirror_cfg_write(idx, value[CFG_DATA_W-1:0]);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pair(sample_t l, sample_t r);
    pending_pairs_q.push_back({l, r});
  endtask

  initial begin : stimulus
    int phase, n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    audio_in_if.valid = 1'b0;
    audio_in_if.sample_left = '0;
    audio_in_if.sample_right = '0;
    audio_out_if.ready = 1'b0;
    in_busy = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    out_mismatches = 0;

    // Register and line state after reset.
    enable_cfg      = 1'b0;
    comb1_len_cfg   = COMB1_LEN_RST;
    comb2_len_cfg   = COMB2_LEN_RST;
    allpass_len_cfg = ALLPASS_LEN_RST;
    decay_cfg       = DECAY_RST;
    mix_cfg         = MIX_RST;
    comb1_pos = 0;
    comb2_pos = 0;
    allpass_pos = 0;
    for (int c = 0; c < 2; c++) begin
      foreach (comb1_mem[c][i]) comb1_mem[c][i] = '0;
      foreach (comb2_mem[c][i]) comb2_mem[c][i] = '0;
      foreach (allpass_mem[c][i]) allpass_mem[c][i] = '0;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Bypass straight out of reset.
    queue_pair(S_MAX, S_MIN);
    queue_pair(S_MIN, S_MAX);
    queue_pair('0, '1);
    queue_pair(sample_t'(24'h555555), sample_t'(24'hAAAAAA));
    drain_pipeline();

    // Short lines, feedback just below one and fully wet: drives the stores into saturation.
    cfg_write(REG_ENABLE, 1);
    cfg_write(REG_COMB1_LEN, 3);
    cfg_write(REG_COMB2_LEN, 5);
    cfg_write(REG_ALLPASS_LEN, 2);
    cfg_write(REG_DECAY, 65535);
    cfg_write(REG_MIX, 65536);
    cfg_release();
    repeat (6) queue_pair(S_MAX, S_MIN);
    repeat (4) queue_pair(S_MIN, S_MAX);
    queue_pair('0, '0);
    queue_pair('1, sample_t'(1));
    drain_pipeline();

    // Zero length, lengths past the line depth, mix above one, undecoded indexes.
    cfg_write(REG_COMB1_LEN, 0);
    cfg_write(REG_COMB2_LEN, 8191);
    cfg_write(REG_ALLPASS_LEN, 1023);
    cfg_write(REG_DECAY, 0);
    cfg_write(REG_MIX, 131071);
    cfg_write(REG_UNUSED_LO, $urandom_range(131071, 0));
    cfg_write(REG_UNUSED_HI, $urandom_range(131071, 0));
    cfg_release();
    queue_pair(S_MAX, S_MAX);
    queue_pair(S_MIN, S_MIN);
    queue_pair(sample_t'(1), '1);
    queue_pair('0, S_MAX);
    queue_pair(S_MIN, '0);
    drain_pipeline();

    // Random phases; each phase has its own setting and idling pattern.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      drain_pipeline();
      case (phase)
        1: begin
          // Full-depth lines with the strongest feedback.
          cfg_write(REG_ENABLE, 1);
          cfg_write(REG_COMB1_LEN, C1_D);
          cfg_write(REG_COMB2_LEN, C2_D);
          cfg_write(REG_ALLPASS_LEN, AP_D);
          cfg_write(REG_DECAY, 65535);
          cfg_write(REG_MIX, 65536);
        end
        2: begin
          // Single-sample lines, no feedback, fully dry.
          cfg_write(REG_COMB1_LEN, 1);
          cfg_write(REG_COMB2_LEN, 1);
          cfg_write(REG_ALLPASS_LEN, 1);
          cfg_write(REG_DECAY, 0);
          cfg_write(REG_MIX, 0);
        end
        3: begin
          // Gains only, so the positions carry on from the last phase.
          cfg_write(REG_DECAY, $urandom_range(65535, 0));
          cfg_write(REG_MIX, pick_mix());
        end
        5: begin
          // Bypass while the lines keep their contents.
          cfg_write(REG_ENABLE, 0);
          cfg_write(REG_MIX, pick_mix());
        end
        default: begin
          cfg_write(REG_ENABLE, 1);
          cfg_write(REG_COMB1_LEN, pick_len(48, 8191));
          cfg_write(REG_COMB2_LEN, pick_len(64, 8191));
          cfg_write(REG_ALLPASS_LEN, pick_len(24, 1023));
          cfg_write(REG_DECAY, ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535, 0));
          cfg_write(REG_MIX, pick_mix());
        end
      endcase
      cfg_release();
      for (n = 0; n < PHASE_ITEMS; n++)
        queue_pair(rand_sample(), rand_sample());
    end

    drain_pipeline();
    repeat (10) @(posedge clk);
    if (out_mismatches == 0 && expected_mix_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/scr_pkg.sv
hw/rtl/scr_stream_if.sv
hw/rtl/scr_ram.sv
hw/rtl/scr_pos.sv
hw/rtl/scr_lane.sv
hw/rtl/scr_merge.sv
hw/rtl/stereo_comb_allpass_reverb.sv
sim/stereo_comb_allpass_reverb_tb.sv
